### hw/rtl/bpa_pkg.sv
// Shared types, constants and helpers for the buddy page allocator.
package bpa_pkg;

   localparam int LEAF_PAGES_DEF = 1024;
   localparam int PAGES_W        = 11;
   localparam int OFFSET_W       = 10;
   localparam int STATUS_W       = 2;
   localparam int LOG_W          = 4;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_BAD_SIZE   = 2'd2,
      ST_BAD_OFFSET = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ROOT_RD,
      S_ROOT_CHK,
      S_DESC_RD,
      S_DESC_CHK,
      S_MARK,
      S_UP_RD,
      S_UP_WR,
      S_CLIMB_RD,
      S_CLIMB_CHK,
      S_DONE
   } state_type;

   // Smallest k with 2**k >= v, for v >= 1.
   function automatic logic [LOG_W-1:0] pages_log2(input logic [PAGES_W-1:0] v);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int i = 0; i < PAGES_W; i++) begin
         if (32'(v) > (32'd1 << i)) begin
            k = LOG_W'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

### hw/rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
   parameter int Width = 11,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/buddy_page_allocator_core.sv
// Buddy page allocator: one request at a time over a longest-free-run tree held in a RAM.
// After reset the block runs a clearing pass that loads every tree node with its span;
// req_stall stays high until it is done. Each tree level takes a read of a node through
// the single registered RAM read port and a step to compare, pick or write. An allocate
// walks down from the root to its block, marks it and rewrites each parent on the way up;
// a free climbs from its leaf to the allocated node, restores it and rewrites the parents
// above it. Requests rejected on their fields go straight to the response. A finished
// response waits in the output register, so the next request can be taken meanwhile.
module buddy_page_allocator_core #(
   parameter int LeafPages = bpa_pkg::LEAF_PAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [bpa_pkg::PAGES_W-1:0]   req_alloc_pages,
   input  logic [bpa_pkg::OFFSET_W-1:0]  req_free_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bpa_pkg::OFFSET_W-1:0]  rsp_block_offset,
   output logic [bpa_pkg::PAGES_W-1:0]   rsp_block_pages
);

   localparam int Lvl   = $clog2(LeafPages);
   localparam int Depth = 2 * LeafPages;
   localparam int NW    = Lvl + 1;
   localparam int VW    = Lvl + 1;
   localparam int LW    = Lvl;
   localparam int PW    = bpa_pkg::PAGES_W;
   localparam int OW    = bpa_pkg::OFFSET_W;

   bpa_pkg::state_type  state_ff, state_in;
   bpa_pkg::status_type stat_ff, stat_in;
   logic                op_ff, op_in;
   logic [NW-1:0]       node_ff, node_in;
   logic [VW-1:0]       span_ff, span_in;
   logic [VW-1:0]       size_ff, size_in;
   logic [VW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       offs_ff, offs_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [OW-1:0]       rsp_offset_ff;
   logic [PW-1:0]       rsp_pages_ff;

   logic                wr_en;
   logic [NW-1:0]       wr_addr;
   logic [VW-1:0]       wr_data;
   logic [NW-1:0]       rd_addr;
   logic [VW-1:0]       rd_data;

   logic                accept;
   logic                bad_size;
   logic                too_big;
   logic                bad_offset;
   logic [bpa_pkg::LOG_W-1:0] size_log;
   logic                fits;
   logic                at_root;
   logic                hit;
   logic                out_free;
   logic [VW-1:0]       span_half;
   logic [VW-1:0]       span_up;
   logic [VW:0]         pair_sum;
   logic [VW-1:0]       pair_max;
   logic [VW-1:0]       up_val;
   logic                load_rsp;

   bpa_ram #(
      .Width(VW),
      .Depth(Depth)
   ) u_tree (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall  = reset || (state_ff != bpa_pkg::S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign bad_size   = (req_alloc_pages == '0);
   assign size_log   = bpa_pkg::pages_log2(req_alloc_pages);
   assign too_big    = (32'(size_log) > Lvl);
   assign bad_offset = (32'(req_free_offset) >= LeafPages);

   // Shared level unit: one compare, one add and one max per tree level.
   assign fits      = (rd_data >= size_ff);
   assign at_root   = (node_ff == NW'(1));
   assign hit       = (rd_data == '0);
   assign span_half = span_ff >> 1;
   assign span_up   = span_ff << 1;
   assign pair_sum  = {1'b0, cur_ff} + {1'b0, rd_data};
   assign pair_max  = (cur_ff > rd_data) ? cur_ff : rd_data;
   // Freeing merges two wholly free buddies into one run of the parent span.
   assign up_val    = ((op_ff == bpa_pkg::OP_FREE) && (pair_sum == {1'b0, span_up}))
                      ? span_up : pair_max;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == bpa_pkg::S_DONE) && out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpa_pkg::S_CLEAR: begin
            if (node_ff == NW'(Depth - 1)) state_in = bpa_pkg::S_IDLE;
         end
         bpa_pkg::S_IDLE: begin
            if (accept) begin
               if (req_op == bpa_pkg::OP_ALLOC) begin
                  state_in = (bad_size || too_big) ? bpa_pkg::S_DONE : bpa_pkg::S_ROOT_RD;
               end else begin
                  state_in = bad_offset ? bpa_pkg::S_DONE : bpa_pkg::S_CLIMB_RD;
               end
            end
         end
         bpa_pkg::S_ROOT_RD: state_in = bpa_pkg::S_ROOT_CHK;
         bpa_pkg::S_ROOT_CHK: begin
            if (!fits)                  state_in = bpa_pkg::S_DONE;
            else if (span_ff == size_ff) state_in = bpa_pkg::S_MARK;
            else                        state_in = bpa_pkg::S_DESC_RD;
         end
         bpa_pkg::S_DESC_RD: state_in = bpa_pkg::S_DESC_CHK;
         bpa_pkg::S_DESC_CHK: begin
            state_in = (span_half == size_ff) ? bpa_pkg::S_MARK : bpa_pkg::S_DESC_RD;
         end
         bpa_pkg::S_MARK: state_in = at_root ? bpa_pkg::S_DONE : bpa_pkg::S_UP_RD;
         bpa_pkg::S_UP_RD: state_in = bpa_pkg::S_UP_WR;
         bpa_pkg::S_UP_WR: begin
            state_in = ((node_ff >> 1) == NW'(1)) ? bpa_pkg::S_DONE : bpa_pkg::S_UP_RD;
         end
         bpa_pkg::S_CLIMB_RD: state_in = bpa_pkg::S_CLIMB_CHK;
         bpa_pkg::S_CLIMB_CHK: begin
            if (at_root)  state_in = bpa_pkg::S_DONE;
            else if (hit) state_in = bpa_pkg::S_UP_RD;
            else          state_in = bpa_pkg::S_CLIMB_RD;
         end
         bpa_pkg::S_DONE: begin
            if (out_free) state_in = bpa_pkg::S_IDLE;
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      stat_in = stat_ff;
      op_in   = op_ff;
      node_in = node_ff;
      span_in = span_ff;
      size_in = size_ff;
      cur_in  = cur_ff;
      offs_in = offs_ff;
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = cur_ff;
      rd_addr = node_ff;
      case (state_ff)
         bpa_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = span_ff;
            node_in = node_ff + NW'(1);
            // span halves when the next node opens a new level
            if (((node_ff + NW'(1)) & node_ff) == '0) span_in = span_half;
         end
         bpa_pkg::S_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               node_in = NW'(1);
               span_in = VW'(LeafPages);
               offs_in = '0;
               stat_in = bpa_pkg::ST_OK;
               size_in = VW'(1) << size_log;
               if (req_op == bpa_pkg::OP_ALLOC) begin
                  if (bad_size) begin
                     stat_in = bpa_pkg::ST_BAD_SIZE;
                     size_in = '0;
                  end else if (too_big) begin
                     stat_in = bpa_pkg::ST_NO_SPACE;
                     size_in = '0;
                  end
               end else begin
                  size_in = '0;
                  if (bad_offset) begin
                     stat_in = bpa_pkg::ST_BAD_OFFSET;
                  end else begin
                     node_in = NW'(LeafPages + int'(req_free_offset));
                     span_in = VW'(1);
                     offs_in = LW'(req_free_offset);
                  end
               end
            end
         end
         bpa_pkg::S_ROOT_CHK: begin
            if (!fits) begin
               stat_in = bpa_pkg::ST_NO_SPACE;
               size_in = '0;
            end
         end
         bpa_pkg::S_DESC_RD: begin
            rd_addr = node_ff << 1;
         end
         bpa_pkg::S_DESC_CHK: begin
            node_in = {node_ff[NW-2:0], !fits};
            span_in = span_half;
            if (!fits) offs_in = offs_ff + LW'(span_half);
         end
         bpa_pkg::S_MARK: begin
            wr_en   = 1'b1;
            wr_data = '0;
            cur_in  = '0;
         end
         bpa_pkg::S_UP_RD: begin
            rd_addr = node_ff ^ NW'(1);
         end
         bpa_pkg::S_UP_WR: begin
            wr_en   = 1'b1;
            wr_addr = node_ff >> 1;
            wr_data = up_val;
            cur_in  = up_val;
            node_in = node_ff >> 1;
            span_in = span_up;
         end
         bpa_pkg::S_CLIMB_CHK: begin
            if (hit) begin
               wr_en   = 1'b1;
               wr_data = span_ff;
               cur_in  = span_ff;
               size_in = span_ff;
            end else if (at_root) begin
               stat_in = bpa_pkg::ST_BAD_OFFSET;
               offs_in = '0;
            end else begin
               node_in = node_ff >> 1;
               span_in = span_up;
               offs_in = offs_ff & ~LW'(span_up - VW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpa_pkg::S_CLEAR;
         node_ff      <= NW'(1);
         span_ff      <= VW'(LeafPages);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      op_ff   <= op_in;
      size_ff <= size_in;
      cur_ff  <= cur_in;
      offs_ff <= offs_in;
      if (load_rsp) begin
         rsp_status_ff <= stat_ff;
         rsp_offset_ff <= OW'(offs_ff);
         rsp_pages_ff  <= PW'(size_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_block_pages  = rsp_pages_ff;

`ifndef SYNTHESIS
   a_desc_size_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_DESC_RD) |-> (size_ff < span_ff))
      else $error("descent past the requested block size");

   a_no_write_node_zero: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != '0))
      else $error("tree write to unused node zero");

   a_ok_has_size: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bpa_pkg::S_DONE) && (stat_ff == bpa_pkg::ST_OK)) |-> (size_ff != '0))
      else $error("successful request with zero block size");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != bpa_pkg::S_IDLE))
      else $error("accepted request did not start");

   a_climb_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_CLIMB_RD) |-> (node_ff != '0))
      else $error("free climb went past the root");
`endif

endmodule
